@@ src/iee_pkg.sv @@
// Package for the infix expression evaluator.
// Holds the sequencer states, operator codes, character classes and ASCII codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_MUL,
        CLS_DIV,
        CLS_ADD,
        CLS_SUB,
        CLS_OTHER
    } t_cls;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

`default_nettype wire

@@ src/infix_expression_evaluator.sv @@
// Top level of the infix expression evaluator: one character per transfer.
// Shared shift-add multiplier and restoring divider under a small sequencer.
// Depends on iee_pkg.
//
// Per character: a digit or ignored code is taken in ST_IDLE alone; an operator with no
// pending product, or a divide by zero, goes on to ST_FINISH; closing a multiply runs the
// one-bit-per-cycle multiply loop, then ST_FINISH; a divide runs its one-bit-per-cycle loop,
// then ST_DIVFIX and ST_FINISH. The last character always closes, and the result posts in
// the cycle after ST_FINISH, held until taken. Not ready while busy. Synchronous active-low reset.
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_end_of_expr,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_value,
    output logic             o_div_by_zero
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    t_cls                   r_cls, n_cls;
    logic                   r_last, n_last;
    logic                   r_add_neg, n_add_neg;
    logic                   r_err, n_err;
    logic                   r_qneg, n_qneg;
    logic [WORD_BITS-1:0]   r_sum, n_sum;
    logic [WORD_BITS-1:0]   r_term, n_term;
    logic [WORD_BITS-1:0]   r_acc, n_acc;
    logic [WORD_BITS-1:0]   r_opa, n_opa;    // multiplicand / divisor
    logic [WORD_BITS-1:0]   r_opb, n_opb;    // multiplier / dividend-quotient
    logic [WORD_BITS-1:0]   r_acc2, n_acc2;  // product / remainder
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [31:0]            r_value, n_value;
    logic                   r_dbz, n_dbz;

    t_cls                   w_cls;
    logic [WORD_BITS-1:0]   w_acc_digit;
    logic [WORD_BITS-1:0]   w_x;
    logic [WORD_BITS:0]     w_rem_sh;
    logic [WORD_BITS:0]     w_rem_sub;
    logic [WORD_BITS-1:0]   w_te;
    logic [WORD_BITS-1:0]   w_sum_next;
    logic [31:0]            w_out;

    always_comb begin
        if (i_char_code >= CH_ZERO && i_char_code <= CH_NINE) begin
            w_cls = CLS_DIGIT;
        end else if (i_char_code == CH_STAR) begin
            w_cls = CLS_MUL;
        end else if (i_char_code == CH_SLASH) begin
            w_cls = CLS_DIV;
        end else if (i_char_code == CH_PLUS) begin
            w_cls = CLS_ADD;
        end else if (i_char_code == CH_MINUS) begin
            w_cls = CLS_SUB;
        end else begin
            w_cls = CLS_OTHER;
        end
    end

    assign w_acc_digit = (r_acc << 3) + (r_acc << 1) + WORD_BITS'(i_char_code[3:0]);
    assign w_x         = (w_cls == CLS_DIGIT) ? w_acc_digit : r_acc;

    assign w_rem_sh  = {r_acc2, r_opb[WORD_BITS-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_opa};

    // trailing '*' or '/' closes against a zero operand
    assign w_te       = (r_cls == CLS_MUL || r_cls == CLS_DIV) ? '0 : r_term;
    assign w_sum_next = r_add_neg ? (r_sum - w_te) : (r_sum + w_te);

    generate
        if (WORD_BITS >= 32) begin : g_trunc
            assign w_out = w_sum_next[31:0];
        end else begin : g_sext
            assign w_out = {{(32 - WORD_BITS){w_sum_next[WORD_BITS-1]}}, w_sum_next};
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cls     = r_cls;
        n_last    = r_last;
        n_add_neg = r_add_neg;
        n_err     = r_err;
        n_qneg    = r_qneg;
        n_sum     = r_sum;
        n_term    = r_term;
        n_acc     = r_acc;
        n_opa     = r_opa;
        n_opb     = r_opb;
        n_acc2    = r_acc2;
        n_cnt     = r_cnt;
        n_value   = r_value;
        n_dbz     = r_dbz;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cls  = w_cls;
                    n_last = i_end_of_expr;
                    if (w_cls == CLS_DIGIT && !i_end_of_expr) begin
                        n_acc = w_acc_digit;
                    end else if (w_cls == CLS_OTHER && !i_end_of_expr) begin
                        n_acc = r_acc;
                    end else begin
                        n_acc = '0;
                        n_op  = OP_NONE;
                        n_cnt = '0;
                        unique case (r_op)
                            OP_MUL: begin
                                n_opa   = r_term;
                                n_opb   = w_x;
                                n_acc2  = '0;
                                n_state = ST_MUL;
                            end
                            OP_DIV: begin
                                if (w_x == '0) begin
                                    n_term  = '0;
                                    n_err   = 1'b1;
                                    n_state = ST_FINISH;
                                end else begin
                                    n_opa   = w_x[WORD_BITS-1] ? (~w_x + 1'b1) : w_x;
                                    n_opb   = r_term[WORD_BITS-1] ? (~r_term + 1'b1) : r_term;
                                    n_acc2  = '0;
                                    n_qneg  = w_x[WORD_BITS-1] ^ r_term[WORD_BITS-1];
                                    n_state = ST_DIV;
                                end
                            end
                            default: begin
                                n_term  = w_x;
                                n_state = ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            ST_MUL: begin
                n_acc2 = r_opb[0] ? (r_acc2 + r_opa) : r_acc2;
                n_opa  = r_opa << 1;
                n_opb  = r_opb >> 1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_term  = n_acc2;
                    n_state = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (!w_rem_sub[WORD_BITS]) begin
                    n_acc2 = w_rem_sub[WORD_BITS-1:0];
                    n_opb  = {r_opb[WORD_BITS-2:0], 1'b1};
                end else begin
                    n_acc2 = w_rem_sh[WORD_BITS-1:0];
                    n_opb  = {r_opb[WORD_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DIVFIX;
                end
            end
            ST_DIVFIX: begin
                n_term  = r_qneg ? (~r_opb + 1'b1) : r_opb;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (r_last) begin
                    n_value   = w_out;
                    n_dbz     = r_err | (r_cls == CLS_DIV);
                    n_sum     = '0;
                    n_term    = '0;
                    n_acc     = '0;
                    n_op      = OP_NONE;
                    n_add_neg = 1'b0;
                    n_err     = 1'b0;
                    n_state   = ST_OUT;
                end else begin
                    n_state = ST_IDLE;
                    case (r_cls)
                        CLS_MUL: n_op = OP_MUL;
                        CLS_DIV: n_op = OP_DIV;
                        CLS_ADD, CLS_SUB: begin
                            n_sum     = w_sum_next;
                            n_term    = '0;
                            n_add_neg = (r_cls == CLS_SUB);
                        end
                        default: n_op = r_op;
                    endcase
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_NONE;
            r_cls     <= CLS_OTHER;
            r_last    <= 1'b0;
            r_add_neg <= 1'b0;
            r_err     <= 1'b0;
            r_sum     <= '0;
            r_term    <= '0;
            r_acc     <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cls     <= n_cls;
            r_last    <= n_last;
            r_add_neg <= n_add_neg;
            r_err     <= n_err;
            r_sum     <= n_sum;
            r_term    <= n_term;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qneg  <= n_qneg;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_acc2  <= n_acc2;
        r_value <= n_value;
        r_dbz   <= n_dbz;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_value       = r_value;
    assign o_div_by_zero = r_dbz;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for infix_expression_evaluator: streams ASCII expressions in,
// predicts each value and div-by-zero flag, and checks every result transfer in order.
// Depends on iee_pkg and infix_expression_evaluator.
`timescale 1ns / 1ps

module tb_top;
    import iee_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] value;
        logic        div_by_zero;
    } t_expr_result;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HEAVY
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_end_of_expr = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value;
    logic        o_div_by_zero;

    // expression evaluator shadow state
    logic [31:0] sum_acc;
    logic [31:0] term_acc;
    logic [31:0] num_acc;
    logic        sub_term;
    t_op         mul_op;
    logic        zero_div_seen;

    t_expr_result expr_results_q[$];
    t_expr_result got_exp;
    logic [7:0]   expr_chars[$];

    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    int       item_cnt = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b0;
    bit       hold_req = 1'b0;
    int       hold_left = 0;
    int       rx_cnt = 0;
    t_rx_mode rx_mode = RX_FREE;

    infix_expression_evaluator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_div_by_zero (o_div_by_zero)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("infix_expression_evaluator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    task automatic clear_eval();
        sum_acc = '0;
        term_acc = '0;
        num_acc = '0;
        sub_term = 1'b0;
        mul_op = OP_NONE;
        zero_div_seen = 1'b0;
    endtask

    task automatic close_number();
        case (mul_op)
            OP_MUL: term_acc = term_acc * num_acc;
            OP_DIV: begin
                if (num_acc == '0) begin
                    zero_div_seen = 1'b1;
                    term_acc = '0;
                end else begin
                    term_acc = trunc_div(term_acc, num_acc);
                end
            end
            default: term_acc = num_acc;
        endcase
        num_acc = '0;
        mul_op = OP_NONE;
    endtask

    task automatic close_term();
        sum_acc = sub_term ? sum_acc - term_acc : sum_acc + term_acc;
        term_acc = '0;
        sub_term = 1'b0;
    endtask

    task automatic eval_char(input logic [7:0] c, input logic last);
        t_expr_result res;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
        end else if (c == CH_STAR || c == CH_SLASH) begin
            close_number();
            mul_op = (c == CH_STAR) ? OP_MUL : OP_DIV;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            close_number();
            close_term();
            sub_term = (c == CH_MINUS);
        end
        if (last) begin
            close_number();
            close_term();
            res.value = sum_acc;
            res.div_by_zero = zero_div_seen;
            expr_results_q.insert(expr_results_q.size(), res);
            clear_eval();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expr_results_q.size() == 0) begin
                $error("unexpected result transfer: value %0d div_by_zero %0b",
                       $signed(o_value), o_div_by_zero);
                mismatch_cnt++;
            end else begin
                got_exp = expr_results_q.pop_front();
                if (o_value !== got_exp.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(got_exp.value), $signed(o_value));
                    mismatch_cnt++;
                end
                if (o_div_by_zero !== got_exp.div_by_zero) begin
                    $error("div_by_zero: expected %0b, got %0b",
                           got_exp.div_by_zero, o_div_by_zero);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side stall pattern, with a long hold on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_cnt++;
        if (rx_cnt % 256 == 0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_RANDOM:   i_stall = ($urandom_range(0, 2) == 0);
                RX_PERIODIC: i_stall = ((rx_cnt % 7) < 3);
                RX_HEAVY:    i_stall = ($urandom_range(0, 3) != 0);
                default:     i_stall = 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Character sender
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        i_valid = 1'b1;
        i_char_code = c;
        i_end_of_expr = last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        eval_char(c, last);
        if (burst_left > 0)
            burst_left--;
        item_cnt++;
    endtask

    task automatic send_str(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], last && (i == s.len() - 1));
    endtask

    task automatic queue_char(input logic [7:0] c);
        expr_chars.insert(expr_chars.size(), c);
    endtask

    task automatic push_number();
        int r;
        int ndig;
        r = $urandom_range(0, 99);
        if (r < 60)
            ndig = 1;
        else if (r < 85)
            ndig = $urandom_range(2, 3);
        else if (r < 95)
            ndig = $urandom_range(4, 6);
        else
            ndig = $urandom_range(9, 12);
        repeat (ndig)
            queue_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_operator();
        case ($urandom_range(0, 3))
            0: queue_char(CH_PLUS);
            1: queue_char(CH_MINUS);
            2: queue_char(CH_STAR);
            default: queue_char(CH_SLASH);
        endcase
    endtask

    task automatic push_filler();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            queue_char(8'($urandom_range(0, 255)));
        else if (r < 3)
            queue_char(CH_SPACE);
    endtask

    // mostly well-formed: operand (op operand)*, with gaps, noise and broken ends
    task automatic build_expr();
        string wrap_case;
        int nterms;
        wrap_case = "2147483648/4294967295";
        expr_chars.delete();
        if ($urandom_range(0, 29) == 0) begin
            for (int i = 0; i < wrap_case.len(); i++)
                queue_char(wrap_case[i]);
            if ($urandom_range(0, 1))
                queue_char(CH_MINUS);
        end
        nterms = ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 6);
        if (nterms > 0 && $urandom_range(0, 7) == 0)
            push_operator();
        for (int t = 0; t < nterms; t++) begin
            push_filler();
            if ($urandom_range(0, 11) != 0)
                push_number();
            push_filler();
            if (t < nterms - 1 || $urandom_range(0, 9) == 0)
                push_operator();
        end
        if (expr_chars.size() == 0 || $urandom_range(0, 9) == 0)
            queue_char(($urandom_range(0, 1)) ? CH_SPACE : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_expr();
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_missing_operands();
        send_str("-5", 1'b1);
        send_str("3*", 1'b1);
    endtask

    task automatic test_div_by_zero();
        send_str("7/0", 1'b1);
    endtask

    task automatic test_precedence();
        send_str("12+2*3-", 1'b0);
        send_char(8'hFF, 1'b0);
        send_str("8/3 ", 1'b1);
    endtask

    task automatic test_random_exprs(input int n_items);
        int stop_at;
        stop_at = item_cnt + n_items;
        while (item_cnt < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                gaps_on = !gaps_on;
            build_expr();
            send_expr();
        end
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_req = 1'b1;
        repeat (8)
            send_str("6*7+1", 1'b1);
    endtask

    initial begin
        clear_eval();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_expr();
        test_missing_operands();
        test_div_by_zero();
        test_precedence();
        test_random_exprs(RANDOM_ITEMS / 2);
        test_backpressure();
        test_random_exprs(RANDOM_ITEMS / 2);

        @(negedge i_clk);
        i_valid = 1'b0;
        i_end_of_expr = 1'b0;
        while (expr_results_q.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("infix_expression_evaluator: match");
        else
            $display("infix_expression_evaluator: mismatch");
        $finish;
    end

endmodule

@@ infix_expression_evaluator.f @@
src/iee_pkg.sv
src/infix_expression_evaluator.sv
tb/tb_top.sv
